### hdl/rwlsb_pkg.sv
// Shared types, constants and helper functions for the IPv4 field W-LSB encoder.
`default_nettype none

package rwlsb_pkg;

  // Sliding window depth and TTL repeat limit.
  localparam int unsigned WINDOW_DEPTH   = 4;
  localparam int unsigned TTL_REPEAT_MAX = 3;

  // Derived widths.
  localparam int unsigned WIN_IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned WIN_CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned RPT_W     = $clog2(TTL_REPEAT_MAX + 1);

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ID_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREV_ID_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CTX_TTL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CTX_DF       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CTX_DSCP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL_SHIFT_P  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_SPAN     = 3'd6;

  // Reset value of the window span register.
  localparam logic [2:0] WIN_SPAN_RESET = 3'd4;

  // Header constants.
  localparam logic [3:0] IPV4_VERSION = 4'd4;
  localparam int unsigned DF_BIT      = 6;

  // W-LSB shifts for the IP-ID delta and full field widths.
  localparam logic [15:0] ID_SHIFT_P3 = 16'd3;
  localparam logic [15:0] ID_SHIFT_P1 = 16'd1;
  localparam logic [4:0]  ID_FULL_BITS  = 5'd16;
  localparam logic [3:0]  TTL_FULL_BITS = 4'd8;

  // IP-ID behavior codes.
  typedef enum logic [1:0] {
    ID_SEQ      = 2'd0,
    ID_SEQ_SWAP = 2'd1,
    ID_RANDOM   = 2'd2,
    ID_ZERO     = 2'd3
  } id_mode_e;

  // Configuration register contents.
  typedef struct packed {
    id_mode_e          id_mode;
    id_mode_e          prev_id_mode;
    logic [7:0]        ctx_ttl;
    logic              ctx_df;
    logic [5:0]        ctx_dscp;
    logic signed [7:0] ttl_shift_p;
    logic [2:0]        win_span;
  } cfg_t;

  // Register contents after reset.
  localparam cfg_t CFG_RESET = '{
    id_mode:      ID_SEQ,
    prev_id_mode: ID_SEQ,
    ctx_ttl:      8'h00,
    ctx_df:       1'b0,
    ctx_dscp:     6'h00,
    ttl_shift_p:  8'sh00,
    win_span:     WIN_SPAN_RESET
  };

  // One header beat.
  typedef struct packed {
    logic [3:0]  ip_version;
    logic [7:0]  ttl;
    logic [15:0] ip_ident;
    logic [15:0] frag_word;
    logic [5:0]  dscp;
    logic [15:0] msn;
  } hdr_t;

  // One result beat.
  typedef struct packed {
    logic        accepted;
    logic        ttl_irregular;
    logic        id_mode_changed;
    logic [15:0] id_delta;
    logic [4:0]  id_bits_p3;
    logic [4:0]  id_bits_p1;
    logic        df_changed;
    logic        dscp_diff;
    logic        ttl_changed;
    logic [3:0]  ttl_bits;
  } res_t;

  // Window status seen by the encoder.
  typedef struct packed {
    logic [WINDOW_DEPTH-1:0] used;
    logic                    empty;
  } win_stat_t;

  // Number of significant bits in a 16-bit value.
  function automatic logic [4:0] bit_len16(input logic [15:0] x);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) begin
        n = 5'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### hdl/rwlsb_if.sv
// Valid/ready channel interfaces for header beats and result beats.
`default_nettype none

interface rwlsb_hdr_if;
  logic              valid;
  logic              ready;
  rwlsb_pkg::hdr_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rwlsb_res_if;
  logic              valid;
  logic              ready;
  rwlsb_pkg::res_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/rwlsb_cfg.sv
// Configuration register file with effective window width.
`default_nettype none

module rwlsb_cfg (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [rwlsb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [rwlsb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output rwlsb_pkg::cfg_t                           cfg_o,
  output logic [rwlsb_pkg::WIN_CNT_W-1:0]           eff_width_o
);

  rwlsb_pkg::cfg_t cfg_q, cfg_d;

  // Register decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rwlsb_pkg::CFG_ID_MODE:      cfg_d.id_mode      = rwlsb_pkg::id_mode_e'(cfg_data_i[1:0]);
        rwlsb_pkg::CFG_PREV_ID_MODE: cfg_d.prev_id_mode = rwlsb_pkg::id_mode_e'(cfg_data_i[1:0]);
        rwlsb_pkg::CFG_CTX_TTL:      cfg_d.ctx_ttl      = cfg_data_i[7:0];
        rwlsb_pkg::CFG_CTX_DF:       cfg_d.ctx_df       = cfg_data_i[0];
        rwlsb_pkg::CFG_CTX_DSCP:     cfg_d.ctx_dscp     = cfg_data_i[5:0];
        rwlsb_pkg::CFG_TTL_SHIFT_P:  cfg_d.ttl_shift_p  = $signed(cfg_data_i[7:0]);
        rwlsb_pkg::CFG_WIN_SPAN:     cfg_d.win_span     = cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= rwlsb_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  // A width of zero acts as one; a width above the depth acts as the depth.
  always_comb begin
    if (cfg_q.win_span == 3'd0) begin
      eff_width_o = rwlsb_pkg::WIN_CNT_W'(1);
    end else if (32'(cfg_q.win_span) > rwlsb_pkg::WINDOW_DEPTH) begin
      eff_width_o = rwlsb_pkg::WIN_CNT_W'(rwlsb_pkg::WINDOW_DEPTH);
    end else begin
      eff_width_o = rwlsb_pkg::WIN_CNT_W'(cfg_q.win_span);
    end
  end

endmodule

`default_nettype wire

### hdl/rwlsb_window.sv
// Sliding reference window: used bits, fill count, write pointer and stored values.
`default_nettype none

module rwlsb_window (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   push_i,
  input  wire logic [15:0]                            value_i,
  input  wire logic [rwlsb_pkg::WIN_CNT_W-1:0]        eff_width_i,
  output rwlsb_pkg::win_stat_t                        stat_o,
  output logic [rwlsb_pkg::WINDOW_DEPTH-1:0][15:0]    values_o
);

  logic [rwlsb_pkg::WINDOW_DEPTH-1:0]        used_q, used_d;
  logic [rwlsb_pkg::WIN_CNT_W-1:0]           count_q, count_d;
  logic [rwlsb_pkg::WIN_IDX_W-1:0]           next_q, next_d;
  logic [rwlsb_pkg::WINDOW_DEPTH-1:0][15:0]  value_q;
  logic [rwlsb_pkg::WIN_IDX_W-1:0]           slot;
  logic [rwlsb_pkg::WIN_CNT_W-1:0]           slot_inc;

  // A pointer left beyond a lowered width wraps to slot zero.
  always_comb begin
    if (rwlsb_pkg::WIN_CNT_W'(next_q) >= eff_width_i) begin
      slot = '0;
    end else begin
      slot = next_q;
    end
    slot_inc = rwlsb_pkg::WIN_CNT_W'(slot) + rwlsb_pkg::WIN_CNT_W'(1);
  end

  // Next pointer, fill count and used bits after a push.
  always_comb begin
    used_d  = used_q;
    count_d = count_q;
    next_d  = next_q;
    if (push_i) begin
      used_d[slot] = 1'b1;
      if (count_q < eff_width_i) begin
        count_d = count_q + rwlsb_pkg::WIN_CNT_W'(1);
      end
      if (slot_inc >= eff_width_i) begin
        next_d = '0;
      end else begin
        next_d = rwlsb_pkg::WIN_IDX_W'(slot_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      count_q <= '0;
      next_q  <= '0;
    end else begin
      used_q  <= used_d;
      count_q <= count_d;
      next_q  <= next_d;
    end
  end

  // Stored values are read only where the used bit is set.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      value_q[slot] <= value_i;
    end
  end

  assign stat_o.used  = used_q;
  assign stat_o.empty = (count_q == '0);
  assign values_o     = value_q;

endmodule

`default_nettype wire

### hdl/rohc_ipv4_field_wlsb_encoder.sv
// Top level of the IPv4 field W-LSB encoder: input register, encode logic, result register.
//
// Takes one IPv4 header beat per cycle while the result side is ready, and returns one
// result beat per header. A beat whose version is not 4 gives a result with only zeros
// and changes no state. A header is captured in the input register, encoded against
// the two four-entry reference windows while the windows and the TTL repeat counter
// update, and the result lands in the result register; the sustained rate is one
// header per clock while the result side is ready. The input register refills while
// a result waits, so a stall on the result side stalls the header side only once both
// registers are full. Configuration writes take effect in the cycle after the write
// strobe and must be made only while no header is in flight.
`default_nettype none

module rohc_ipv4_field_wlsb_encoder (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rwlsb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [rwlsb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  rwlsb_hdr_if.sink                                hdr_i,
  rwlsb_res_if.source                              res_o
);

  rwlsb_pkg::cfg_t                                cfg;
  logic [rwlsb_pkg::WIN_CNT_W-1:0]                eff_width;

  logic                                           in_valid_q, in_valid_d;
  rwlsb_pkg::hdr_t                                in_data_q;
  logic                                           out_valid_q, out_valid_d;
  rwlsb_pkg::res_t                                out_data_q, res_d;
  logic [rwlsb_pkg::RPT_W-1:0]                    rpt_q, rpt_d;

  logic                                           advance;
  logic                                           hdr_ok;
  logic                                           push;

  rwlsb_pkg::win_stat_t                           id_stat, ttl_stat;
  logic [rwlsb_pkg::WINDOW_DEPTH-1:0][15:0]       id_vals, ttl_vals;

  logic [15:0]                                    id_src;
  logic [15:0]                                    delta;
  logic [15:0]                                    or_p3, or_p1;
  logic [7:0]                                     or_ttl;
  logic                                           id_seq;
  logic                                           ttl_diff;
  logic                                           ttl_chg;
  logic [4:0]                                     ttl_len;

  rwlsb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .eff_width_o (eff_width)
  );

  // Handshake: the input register moves on whenever the result register is free.
  assign advance      = in_valid_q && (!out_valid_q || res_o.ready);
  assign hdr_i.ready  = !in_valid_q || advance;
  assign res_o.valid  = out_valid_q;
  assign res_o.data   = out_data_q;

  assign hdr_ok = (in_data_q.ip_version == rwlsb_pkg::IPV4_VERSION);
  assign push   = advance && hdr_ok;

  always_comb begin
    in_valid_d = in_valid_q;
    if (hdr_i.valid && hdr_i.ready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rpt_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      rpt_q       <= rpt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (hdr_i.valid && hdr_i.ready) begin
      in_data_q <= hdr_i.data;
    end
    if (advance) begin
      out_data_q <= res_d;
    end
  end

  // IP-ID delta, byte-swapped first in swapped mode.
  always_comb begin
    if (cfg.id_mode == rwlsb_pkg::ID_SEQ_SWAP) begin
      id_src = {in_data_q.ip_ident[7:0], in_data_q.ip_ident[15:8]};
    end else begin
      id_src = in_data_q.ip_ident;
    end
    delta = id_src - in_data_q.msn;
  end

  // W-LSB search: the smallest k is the bit length of the OR of all offsets
  // (value - ref + p) over the used entries.
  always_comb begin
    or_p3  = '0;
    or_p1  = '0;
    or_ttl = '0;
    for (int i = 0; i < rwlsb_pkg::WINDOW_DEPTH; i++) begin
      if (id_stat.used[i]) begin
        or_p3 = or_p3 | (delta - id_vals[i] + rwlsb_pkg::ID_SHIFT_P3);
        or_p1 = or_p1 | (delta - id_vals[i] + rwlsb_pkg::ID_SHIFT_P1);
      end
      if (ttl_stat.used[i]) begin
        or_ttl = or_ttl |
                 (in_data_q.ttl - ttl_vals[i][7:0] + $unsigned(cfg.ttl_shift_p));
      end
    end
  end

  assign ttl_len = rwlsb_pkg::bit_len16({8'h00, or_ttl});
  assign id_seq  = (cfg.id_mode == rwlsb_pkg::ID_SEQ) ||
                   (cfg.id_mode == rwlsb_pkg::ID_SEQ_SWAP);

  // TTL change flag holds for TTL_REPEAT_MAX further accepted headers after the last change.
  assign ttl_diff = (in_data_q.ttl != cfg.ctx_ttl);
  always_comb begin
    rpt_d   = rpt_q;
    ttl_chg = 1'b0;
    if (ttl_diff) begin
      ttl_chg = 1'b1;
      if (push) begin
        rpt_d = '0;
      end
    end else if (rpt_q < rwlsb_pkg::RPT_W'(rwlsb_pkg::TTL_REPEAT_MAX)) begin
      ttl_chg = 1'b1;
      if (push) begin
        rpt_d = rpt_q + rwlsb_pkg::RPT_W'(1);
      end
    end
  end

  // Result assembly; a rejected header gives an all-zero result.
  always_comb begin
    res_d = '0;
    if (hdr_ok) begin
      res_d.accepted        = 1'b1;
      res_d.ttl_irregular   = ttl_diff;
      res_d.id_mode_changed = (cfg.id_mode != cfg.prev_id_mode);
      res_d.id_delta        = delta;
      if (!id_seq || id_stat.empty) begin
        res_d.id_bits_p3 = rwlsb_pkg::ID_FULL_BITS;
        res_d.id_bits_p1 = rwlsb_pkg::ID_FULL_BITS;
      end else begin
        res_d.id_bits_p3 = rwlsb_pkg::bit_len16(or_p3);
        res_d.id_bits_p1 = rwlsb_pkg::bit_len16(or_p1);
      end
      res_d.df_changed  = (in_data_q.frag_word[rwlsb_pkg::DF_BIT] != cfg.ctx_df);
      res_d.dscp_diff   = (in_data_q.dscp != cfg.ctx_dscp);
      res_d.ttl_changed = ttl_chg;
      if (ttl_stat.empty) begin
        res_d.ttl_bits = rwlsb_pkg::TTL_FULL_BITS;
      end else begin
        res_d.ttl_bits = ttl_len[3:0];
      end
    end
  end

  rwlsb_window u_id_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .value_i     (delta),
    .eff_width_i (eff_width),
    .stat_o      (id_stat),
    .values_o    (id_vals)
  );

  rwlsb_window u_ttl_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .value_i     ({8'h00, in_data_q.ttl}),
    .eff_width_i (eff_width),
    .stat_o      (ttl_stat),
    .values_o    (ttl_vals)
  );

endmodule

`default_nettype wire
